// File: hdl/blzss_pkg.sv
// ----------------------------------------------------------------------------
// blzss_pkg
// Shared constants, types and helpers of the backward LZSS decoder.
// ----------------------------------------------------------------------------
package blzss_pkg;

    // History window depth; must be a power of two.
    localparam int WINDOW_DEPTH = 8192;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    // Run status codes.
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODED_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LENGTH  = 2'd1;

    // Token field constants.
    localparam logic [4:0]  MATCH_LEN_BIAS  = 5'd3;
    localparam logic [12:0] MATCH_DIST_BIAS = 13'd3;
    localparam logic [3:0]  FLAGS_PER_CTRL  = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_load;
        logic decode_fire;
        logic rd_issue;
        logic copy_fire;
    } blzss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic start_match;
        logic copy_last;
    } blzss_sts_t;

    // End-of-step check: finish or fail once the region or the output runs out.
    function automatic logic [1:0] settle(
        input logic [1:0]  halted,
        input logic        token_half,
        input logic [23:0] left_in,
        input logic [31:0] produced,
        input logic [31:0] out_len
    );
        logic [1:0] res;
        res = halted;
        if (halted == ST_RUN)
        begin
            if (token_half)
            begin
                if (left_in == 24'd0)
                    res = ST_ERR;
            end
            else if ((left_in == 24'd0) || (produced >= out_len))
            begin
                res = ST_DONE;
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/blzss_ctrl.sv
// ----------------------------------------------------------------------------
// blzss_ctrl
// Sequencer: takes an item, lets the datapath decode it, and steps the
// byte-by-byte match copy through the history memory.
// ----------------------------------------------------------------------------
module blzss_ctrl
    import blzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  blzss_sts_t sts,
    output blzss_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_RD     = 2'd2;
    localparam logic [1:0] S_COPY   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.out_free)
                begin
                    cmd.decode_fire = 1'b1;
                    state_next      = sts.start_match ? S_RD : S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_COPY;
            end
            S_COPY:
            begin
                if (sts.out_free)
                begin
                    cmd.copy_fire = 1'b1;
                    state_next    = sts.copy_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hdl/blzss_dpath.sv
// ----------------------------------------------------------------------------
// blzss_dpath
// Decoder state, history memory, configuration registers and output register.
// ----------------------------------------------------------------------------
module blzss_dpath
    import blzss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  blzss_cmd_t           cmd,
    output blzss_sts_t           sts,
    input  logic [7:0]           in_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic [7:0]           out_byte,
    output logic                 byte_valid,
    output logic [1:0]           status,
    output logic                 run_last,
    output logic                 out_valid,
    input  logic                 out_stall
);

    // Configuration.
    logic [23:0] enc_len_reg, enc_len_next;
    logic [31:0] out_len_reg, out_len_next;

    // Run state.
    logic [31:0]       produced_reg, produced_next;
    logic [23:0]       left_reg, left_next;
    logic [7:0]        flag_bits_reg, flag_bits_next;
    logic [3:0]        flags_left_reg, flags_left_next;
    logic              token_half_reg, token_half_next;
    logic [7:0]        token_high_reg, token_high_next;
    logic [1:0]        halted_reg, halted_next;
    logic [4:0]        len_cnt_reg, len_cnt_next;
    logic [WIN_AW-1:0] rd_ptr_reg, rd_ptr_next;

    logic [7:0] byte_reg;
    logic [7:0] rdata_reg;

    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [1:0] status_reg, status_next;
    logic       run_last_reg, run_last_next;
    logic       out_valid_reg, out_valid_next;

    logic [7:0] history_mem [WINDOW_DEPTH];

    // Decode of the held item.
    logic [1:0]  pre_halted;
    logic [23:0] left_dec;
    logic [4:0]  match_len;
    logic [12:0] match_dist;
    logic [31:0] space_left;
    logic        match_bad;
    logic        is_ctrl, is_token_lo, is_token_hi, is_literal;
    logic        out_load;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    assign pre_halted  = settle(halted_reg, token_half_reg, left_reg, produced_reg,
                                out_len_reg);
    assign left_dec    = left_reg - 24'd1;
    assign match_len   = {1'b0, token_high_reg[7:4]} + MATCH_LEN_BIAS;
    assign match_dist  = {1'b0, token_high_reg[3:0], byte_reg} + MATCH_DIST_BIAS;
    assign space_left  = out_len_reg - produced_reg;
    assign match_bad   = (space_left < {27'd0, match_len})
                       || ({19'd0, match_dist} > produced_reg);

    assign is_ctrl     = (pre_halted == ST_RUN) && (flags_left_reg == 4'd0);
    assign is_token_lo = (pre_halted == ST_RUN) && !is_ctrl && token_half_reg;
    assign is_token_hi = (pre_halted == ST_RUN) && !is_ctrl && !token_half_reg
                       && flag_bits_reg[7];
    assign is_literal  = (pre_halted == ST_RUN) && !is_ctrl && !token_half_reg
                       && !flag_bits_reg[7];

    assign sts.start_match = is_token_lo && !match_bad;
    assign sts.copy_last   = (len_cnt_reg == 5'd1);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_load  = (cmd.decode_fire && !sts.start_match) || cmd.copy_fire;
    assign mem_we    = (cmd.decode_fire && is_literal) || cmd.copy_fire;
    assign mem_wdata = cmd.copy_fire ? rdata_reg : byte_reg;

    always_comb
    begin
        enc_len_next    = enc_len_reg;
        out_len_next    = out_len_reg;
        produced_next   = produced_reg;
        left_next       = left_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        token_half_next = token_half_reg;
        token_high_next = token_high_reg;
        halted_next     = halted_reg;
        len_cnt_next    = len_cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        status_next     = status_reg;
        run_last_next   = run_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.decode_fire)
        begin
            out_byte_next   = 8'd0;
            byte_valid_next = 1'b0;
            run_last_next   = 1'b1;
            halted_next     = pre_halted;
            if (pre_halted == ST_RUN)
                left_next = left_dec;
            if (is_ctrl)
            begin
                flag_bits_next  = byte_reg;
                flags_left_next = FLAGS_PER_CTRL;
                if ((left_dec == 24'd0) || (produced_reg >= out_len_reg))
                    halted_next = ST_DONE;
            end
            else if (is_token_lo)
            begin
                token_half_next = 1'b0;
                if (match_bad)
                begin
                    halted_next = ST_ERR;
                end
                else
                begin
                    len_cnt_next    = match_len;
                    rd_ptr_next     = produced_reg[WIN_AW-1:0] - WIN_AW'(match_dist);
                    flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                    flags_left_next = flags_left_reg - 4'd1;
                    if ((left_dec == 24'd0) || (space_left == {27'd0, match_len}))
                        halted_next = ST_DONE;
                end
            end
            else if (is_token_hi)
            begin
                token_high_next = byte_reg;
                token_half_next = 1'b1;
                if (left_dec == 24'd0)
                    halted_next = ST_ERR;
            end
            else if (is_literal)
            begin
                out_byte_next   = byte_reg;
                byte_valid_next = 1'b1;
                produced_next   = produced_reg + 32'd1;
                flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                flags_left_next = flags_left_reg - 4'd1;
                if ((left_dec == 24'd0) || (produced_next == out_len_reg))
                    halted_next = ST_DONE;
            end
            status_next = halted_next;
        end

        if (cmd.copy_fire)
        begin
            out_byte_next   = rdata_reg;
            byte_valid_next = 1'b1;
            run_last_next   = (len_cnt_reg == 5'd1);
            status_next     = halted_reg;
            produced_next   = produced_reg + 32'd1;
            rd_ptr_next     = rd_ptr_reg + WIN_AW'(1);
            len_cnt_next    = len_cnt_reg - 5'd1;
        end

        if (out_load)
            out_valid_next = 1'b1;

        // A write to either length register restarts the run.
        if (cfg_we && ((cfg_index == CFG_ENCODED_LENGTH) || (cfg_index == CFG_OUTPUT_LENGTH)))
        begin
            if (cfg_index == CFG_ENCODED_LENGTH)
                enc_len_next = cfg_data[23:0];
            else
                out_len_next = cfg_data;
            produced_next   = 32'd0;
            left_next       = enc_len_next;
            flag_bits_next  = 8'd0;
            flags_left_next = 4'd0;
            token_half_next = 1'b0;
            token_high_next = 8'd0;
            halted_next     = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_len_reg    <= 24'd0;
            out_len_reg    <= 32'd0;
            produced_reg   <= 32'd0;
            left_reg       <= 24'd0;
            flag_bits_reg  <= 8'd0;
            flags_left_reg <= 4'd0;
            token_half_reg <= 1'b0;
            token_high_reg <= 8'd0;
            halted_reg     <= ST_RUN;
            len_cnt_reg    <= 5'd0;
            rd_ptr_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            enc_len_reg    <= enc_len_next;
            out_len_reg    <= out_len_next;
            produced_reg   <= produced_next;
            left_reg       <= left_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            token_half_reg <= token_half_next;
            token_high_reg <= token_high_next;
            halted_reg     <= halted_next;
            len_cnt_reg    <= len_cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
            byte_reg <= in_byte;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        status_reg     <= status_next;
        run_last_reg   <= run_last_next;
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            history_mem[produced_reg[WIN_AW-1:0]] <= mem_wdata;
        if (cmd.rd_issue)
            rdata_reg <= history_mem[rd_ptr_reg];
    end

    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign status     = status_reg;
    assign run_last   = run_last_reg;
    assign out_valid  = out_valid_reg;

endmodule

// File: hdl/backward_lzss_decompressor.sv
// ----------------------------------------------------------------------------
// backward_lzss_decompressor
// Backward LZSS decoder: encoded bytes in from the region end, decoded bytes
// out from the highest position down, with sticky error and finish status.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid / in_stall    in_byte
//  out       source     out_valid / out_stall  out_byte, byte_valid, status, run_last
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A control byte, a literal, a token high byte or a step after the run has
// stopped is accepted in S_IDLE and then decoded in S_DECODE. For a match token
// of length L, each copied byte is a registered read of the history memory
// (S_RD) followed by its write-back and output (S_COPY).
// Reset clears all run state; the history memory is not cleared, because a
// match can only reach bytes already written in the current run.
// A stalled output register holds the decoder in place until the result is taken.
//
module backward_lzss_decompressor
    import blzss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Encoded input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    // Decoded output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 byte_valid,
    output logic [1:0]           status,
    output logic                 run_last,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    blzss_cmd_t cmd;
    blzss_sts_t sts;

    // Writes are always taken; each valid length-register write restarts the run.
    assign cfg_ready = 1'b1;

    // The controller sequences one item at a time, including its match copy.
    blzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the decoder state, history memory and output register.
    blzss_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_byte    (in_byte),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .run_last   (run_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule

// File: hdl/blzss_checker.sv
// ----------------------------------------------------------------------------
// blzss_checker
// Port-level checks of the backward LZSS decoder, bound to the top level.
// ----------------------------------------------------------------------------
module blzss_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [7:0]           out_byte,
    input logic                 byte_valid,
    input logic [1:0]           status,
    input logic                 run_last,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(run_last) && $stable(byte_valid))
        else $error("stalled result changed");

    // An accepted item is decoded before the next one is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is being decoded");

    // Only match bytes are followed by more results of the same item.
    a_non_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> byte_valid)
        else $error("status-only result not marked last");

    // While a match copy still owes bytes, no new item is taken.
    a_match_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> in_stall)
        else $error("input open during a match copy");

    // Register writes only land while nothing is in flight.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_stall && !out_valid)
        else $error("register written while an item is in flight");

endmodule

bind backward_lzss_decompressor blzss_checker u_blzss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .run_last   (run_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the backward LZSS decoder: encoded byte streams go
// in, and every decoded byte and status result is checked against a predictor.
// ----------------------------------------------------------------------------
//
// The bench keeps its own software copy of the decoder: history window, byte
// counters, flag shifter and token holder. Each item the decoder accepts runs
// through that copy, and the results it would produce are queued. Every
// result the decoder hands out is checked against the oldest queued one.
//
// Stimulus comes in phases. Each phase programs both length registers while
// the decoder is idle, then feeds one encoded stream. A short directed part
// walks the corner cases: literals and matches at the field extremes, an
// overlapping copy, a match that reaches behind the start of the output, a
// token that does not fit in the output space, a full output, a region that
// ends between the two bytes of a token, and the sticky behavior afterwards.
// The random part builds mostly well-formed streams (matches only reach into
// bytes already decoded) and then bends the register values around them, so
// runs end by region end, by full output, by overflow or by truncation. A few
// phases send plain noise.
//
module tb;
    import blzss_pkg::*;

    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
    localparam int TIMEOUT_NS   = 1000000;  // generous: the run needs far less
    localparam int RANDOM_ITEMS = 250;
    localparam int MIN_MATCH    = 3;
    localparam int MAX_MATCH    = 18;
    localparam int MAX_REACH    = 4098;     // farthest distance a token can encode
    localparam int SETTLE_CYCLES = 6;

    // One decoder result as the bench predicts it.
    typedef struct packed {
        logic [7:0] value;
        logic       has_byte;
        logic [1:0] run_st;
        logic       last;
    } decoded_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           in_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic [1:0]           status;
    logic                 run_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENCODED_LENGTH;
    logic [31:0]          cfg_data = 32'd0;

    backward_lzss_decompressor dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .run_last   (run_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a copy of everything the decoder keeps per run.
    // ------------------------------------------------------------------
    logic [23:0] enc_len = 24'd0;
    logic [31:0] out_len = 32'd0;
    logic [7:0]  hist_mem [WINDOW_DEPTH];
    logic [31:0] produced = 32'd0;
    logic [23:0] left_in = 24'd0;
    logic [7:0]  flag_sr = 8'd0;
    logic [3:0]  flags_left = 4'd0;
    logic        tok_pending = 1'b0;
    logic [7:0]  tok_high = 8'd0;
    logic [1:0]  halt_st = ST_RUN;

    decoded_t    predicted_output[$];   // results the decoder still owes
    logic [7:0]  encoded_feed[$];       // items waiting for the driver
    logic [7:0]  stream_buf[$];         // stream being composed for a phase
    int          stream_made;           // decoded size of stream_buf

    int send_idle_pct = 28;
    int recv_idle_pct = 46;
    logic hold_armed = 1'b0;
    int   hold_cnt = 0;
    logic hold_active;

    int mismatches = 0;
    int bytes_fed = 0;
    int results_seen = 0;
    int data_seen = 0;
    int settings = 0;
    int runs_done = 0;
    int runs_err = 0;

    // A register write restarts the run with the new lengths.
    function automatic void restart_run();
        produced    = 32'd0;
        left_in     = enc_len;
        flag_sr     = 8'd0;
        flags_left  = 4'd0;
        tok_pending = 1'b0;
        tok_high    = 8'd0;
        halt_st     = ST_RUN;
    endfunction

    // The run stops once the region is used up or the output space is full.
    // A region that runs out between the two token bytes is an error.
    function automatic void check_run_end();
        if (halt_st == ST_RUN)
        begin
            if (tok_pending)
            begin
                if (left_in == 24'd0)
                    halt_st = ST_ERR;
            end
            else if ((left_in == 24'd0) || (produced >= out_len))
            begin
                halt_st = ST_DONE;
            end
        end
    endfunction

    function automatic void store_byte(input logic [7:0] v);
        hist_mem[produced[WIN_AW-1:0]] = v;
        produced = produced + 32'd1;
    endfunction

    // Runs one accepted encoded byte through the predictor and queues the
    // results it causes: one per decoded byte, or a single status result.
    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0]  emitted[$];
        logic [4:0]  mlen;
        logic [12:0] mdist;
        logic [31:0] src;
        logic [7:0]  v;
        decoded_t    r;
        int          i;

        emitted = {};
        check_run_end();
        if (halt_st == ST_RUN)
        begin
            left_in = left_in - 24'd1;
            if (flags_left == 4'd0)
            begin
                flag_sr    = b;
                flags_left = FLAGS_PER_CTRL;
            end
            else if (tok_pending)
            begin
                mlen  = {1'b0, tok_high[7:4]} + MATCH_LEN_BIAS;
                mdist = {1'b0, tok_high[3:0], b} + MATCH_DIST_BIAS;
                tok_pending = 1'b0;
                if (((out_len - produced) < {27'd0, mlen}) || ({19'd0, mdist} > produced))
                begin
                    halt_st = ST_ERR;
                end
                else
                begin
                    // Byte by byte, so an overlapping copy repeats its pattern.
                    for (i = 0; i < mlen; i++)
                    begin
                        src = produced - {19'd0, mdist};
                        v   = hist_mem[src[WIN_AW-1:0]];
                        store_byte(v);
                        emitted.push_back(v);
                    end
                    flag_sr    = flag_sr << 1;
                    flags_left = flags_left - 4'd1;
                end
            end
            else if (flag_sr[7])
            begin
                tok_high    = b;
                tok_pending = 1'b1;
            end
            else
            begin
                store_byte(b);
                emitted.push_back(b);
                flag_sr    = flag_sr << 1;
                flags_left = flags_left - 4'd1;
            end
            check_run_end();
        end

        if (emitted.size() == 0)
        begin
            r.value    = 8'h00;
            r.has_byte = 1'b0;
            r.run_st   = halt_st;
            r.last     = 1'b1;
            predicted_output.push_back(r);
        end
        else
        begin
            foreach (emitted[k])
            begin
                r.value    = emitted[k];
                r.has_byte = 1'b1;
                r.run_st   = halt_st;
                r.last     = (k == emitted.size() - 1);
                predicted_output.push_back(r);
            end
        end
    endfunction

    function automatic void field_check(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver. The payload only changes when the current item has been
    // taken or nothing is offered, and the decision to idle never looks at
    // in_stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte);
                bytes_fed++;
            end
            if (!in_valid || !in_stall)
            begin
                if ((encoded_feed.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= encoded_feed.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, counted here so the decoder backs up
    // into its input while the driver keeps offering items.
    assign hold_active = hold_armed && (hold_cnt < HOLD_CYCLES);

    always @(posedge clk)
    begin
        if (hold_active)
            hold_cnt <= hold_cnt + 1;
    end

    // ------------------------------------------------------------------
    // Output monitor: random stalls plus the check of every taken result.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;

        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (byte_valid === 1'b1)
                    data_seen++;
                if (predicted_output.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, out_byte 0x%0h status %0d", $time,
                             out_byte, status);
                end
                else
                begin
                    want = predicted_output.pop_front();
                    field_check("out_byte", want.value, out_byte);
                    field_check("byte_valid", want.has_byte, byte_valid);
                    field_check("status", want.run_st, status);
                    field_check("run_last", want.last, run_last);
                end
            end
            out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Register write over the configuration channel; the predictor follows
    // at the edge where the write lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_ENCODED_LENGTH)
            enc_len = value[23:0];
        else
            out_len = value;
        restart_run();
        settings++;
    endtask

    // Wait until every item has gone in and every predicted result has come
    // out, then let the decoder settle back to idle.
    task automatic wait_drained();
        @(negedge clk);
        while ((encoded_feed.size() != 0) || in_valid || (predicted_output.size() != 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program both lengths, feed stream_buf, and wait for the run to drain.
    task automatic play(input logic [23:0] enc, input logic [31:0] olen);
        write_reg(CFG_ENCODED_LENGTH, {8'd0, enc});
        write_reg(CFG_OUTPUT_LENGTH, olen);
        @(negedge clk);
        foreach (stream_buf[i])
            encoded_feed.push_back(stream_buf[i]);
        wait_drained();
        if (halt_st == ST_DONE)
            runs_done++;
        else if (halt_st == ST_ERR)
            runs_err++;
    endtask

    // Builds a well-formed stream: control bytes followed by literals and
    // tokens, where every match reaches only into bytes already decoded.
    // The last group may stop before its eighth flag.
    function automatic void compose_stream(input int groups);
        logic [7:0] body[$];
        logic [7:0] ctrl;
        int g, f, n_el, mlen, mdist, reach, made;

        stream_buf = {};
        made = 0;
        for (g = 0; g < groups; g++)
        begin
            body = {};
            ctrl = 8'h00;
            n_el = (g == groups - 1) ? $urandom_range(1, 8) : 8;
            for (f = 0; f < n_el; f++)
            begin
                if ((made >= MIN_MATCH) && ($urandom_range(0, 99) < 55))
                begin
                    mlen  = $urandom_range(MIN_MATCH, MAX_MATCH);
                    reach = (made < MAX_REACH) ? made : MAX_REACH;
                    // Short distances half the time, to get overlapping copies.
                    if ((reach > 20) && $urandom_range(0, 1))
                        reach = 20;
                    mdist = $urandom_range(MIN_MATCH, reach);
                    ctrl[7 - f] = 1'b1;
                    body.push_back(8'(((mlen - MIN_MATCH) << 4) | ((mdist - MIN_MATCH) >> 8)));
                    body.push_back(8'(mdist - MIN_MATCH));
                    made += mlen;
                end
                else
                begin
                    body.push_back(8'($urandom));
                    made++;
                end
            end
            stream_buf.push_back(ctrl);
            foreach (body[i])
                stream_buf.push_back(body[i]);
        end
        stream_made = made;
    endfunction

    // One random phase. Most shapes keep the stream intact and only move the
    // register values around it; the rest send noise.
    task automatic random_phase(input int groups, input bit plain);
        logic [23:0] enc;
        logic [31:0] olen;
        int shape, cut, extra;

        compose_stream(groups);
        enc   = 24'(stream_buf.size());
        olen  = 32'(stream_made);
        shape = plain ? 0 : $urandom_range(0, 9);
        case (shape)
            1, 2:
                olen = olen + 32'($urandom_range(1, 40));
            3, 4:
            begin
                // Output space ends inside the data: full output or overflow.
                cut  = (stream_made < 20) ? stream_made : 20;
                olen = olen - 32'($urandom_range(1, cut));
            end
            5:
            begin
                // Region cut short, possibly between the two token bytes.
                if (stream_buf.size() > 3)
                    enc = enc - 24'($urandom_range(1, 3));
            end
            6:
            begin
                enc  = 24'hFFFFFF;
                olen = 32'hFFFFFFFF;
            end
            7:
            begin
                stream_buf = {};
                repeat ($urandom_range(5, 20))
                    stream_buf.push_back(8'($urandom));
                enc  = 24'(stream_buf.size());
                olen = 32'($urandom_range(0, 200));
            end
            default:
                ;
        endcase
        // Up to two more bytes; after a stop they return only the sticky status.
        extra = $urandom_range(0, 2);
        repeat (extra)
            stream_buf.push_back(8'($urandom));
        play(enc, olen);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int random_items;

        random_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, with the first idling pattern.
        // Literals 00, FF, 5A, a three-byte match of them, an eighteen-byte
        // overlapping match at the shortest distance, then two more literals.
        stream_buf = '{8'h18, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'hF0, 8'h00,
                       8'h80, 8'h7F};
        play(24'hFFFFFF, 32'hFFFFFFFF);

        // A match that reaches behind the first decoded byte.
        stream_buf = '{8'h80, 8'h00, 8'h01};
        play(24'd100, 32'hFFFFFFFF);

        // A token longer than the space left, then the sticky error status.
        stream_buf = '{8'h40, 8'h11, 8'h00, 8'h00, 8'h22};
        play(24'd50, 32'd3);

        // The output fills up and the run finishes quietly.
        stream_buf = '{8'h00, 8'h11, 8'h22, 8'h33};
        play(24'hFFFFFF, 32'd2);

        // The region ends right after a token high byte.
        stream_buf = '{8'h80, 8'h12, 8'h34};
        play(24'd2, 32'd100);

        // Empty region and no output space: finished before any decoding.
        stream_buf = '{8'hA5};
        play(24'd0, 32'd0);

        // Random part. The first phase is a long intact stream during which
        // the receiver holds off, so the decoder backs up into its input.
        @(negedge clk);
        hold_armed = 1'b1;
        random_phase(4, 1'b1);
        random_items += bytes_fed;

        while (random_items < RANDOM_ITEMS)
        begin
            @(negedge clk);
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 46;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase($urandom_range(1, 4), 1'b0);
            random_items += stream_buf.size();
        end

        wait_drained();
        $display("Fed %0d encoded bytes under %0d register settings; checked %0d results,",
                 bytes_fed, settings, results_seen);
        $display("%0d of them decoded bytes; %0d runs finished and %0d stopped on error.",
                 data_seen, runs_done, runs_err);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a decoder that hangs or never hands out a result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected", predicted_output.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
